// ===== rtl/core/tomq_pkg.sv =====
// Package for the timestamp ordered message queue.
// Holds the shared constants, the operation codes and the cell control struct.
// No dependencies.
package tomq_pkg;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 64;
    localparam int KIND_W       = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        logic capture;
        logic op_pop;
        logic op_replace;
        logic op_insert;
    } t_cell_ctl;

endpackage

// ===== rtl/core/tomq_in_if.sv =====
// Request channel of the timestamp ordered message queue.
// Carries valid, ready and one operation; depends on tomq_pkg.
interface tomq_in_if #(
    parameter int PAYLOAD_BITS = tomq_pkg::PAYLOAD_BITS
);
    logic                       valid;
    logic                       ready;
    logic [tomq_pkg::KIND_W-1:0] kind;
    logic [tomq_pkg::KEY_W-1:0]  key;
    logic [PAYLOAD_BITS-1:0]     payload;

    modport source (output valid, kind, key, payload, input ready);
    modport sink   (input valid, kind, key, payload, output ready);
endinterface

// ===== rtl/core/tomq_out_if.sv =====
// Result channel of the timestamp ordered message queue.
// Carries valid, ready and one result; depends on tomq_pkg.
interface tomq_out_if #(
    parameter int PAYLOAD_BITS = tomq_pkg::PAYLOAD_BITS,
    parameter int CNT_W        = $clog2(tomq_pkg::DEPTH + 1)
);
    logic                       valid;
    logic                       ready;
    logic [CNT_W-1:0]           position;
    logic                       replaced;
    logic                       dropped;
    logic                       found;
    logic [tomq_pkg::KEY_W-1:0] out_key;
    logic [PAYLOAD_BITS-1:0]    out_payload;
    logic [CNT_W-1:0]           entry_count;

    modport source (output valid, position, replaced, dropped, found, out_key, out_payload,
                    entry_count, input ready);
    modport sink   (input valid, position, replaced, dropped, found, out_key, out_payload,
                    entry_count, output ready);
endinterface

// ===== rtl/core/tomq_cell.sv =====
// One slot of the sorted chain; cells run in ascending key order from slot 0.
// Holds key, handle, valid bit and the registered compare flags; depends on tomq_pkg.
module tomq_cell #(
    parameter int PAYLOAD_BITS = tomq_pkg::PAYLOAD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tomq_pkg::t_cell_ctl        i_ctl,
    input  logic [tomq_pkg::KEY_W-1:0] i_cmp_key,
    input  logic [tomq_pkg::KEY_W-1:0] i_new_key,
    input  logic [PAYLOAD_BITS-1:0]    i_new_pay,
    input  logic [tomq_pkg::KEY_W-1:0] i_prev_key,
    input  logic [PAYLOAD_BITS-1:0]    i_prev_pay,
    input  logic                       i_prev_valid,
    input  logic                       i_prev_lt,
    input  logic [tomq_pkg::KEY_W-1:0] i_next_key,
    input  logic [PAYLOAD_BITS-1:0]    i_next_pay,
    input  logic                       i_next_valid,
    output logic [tomq_pkg::KEY_W-1:0] o_key,
    output logic [PAYLOAD_BITS-1:0]    o_pay,
    output logic                       o_valid,
    output logic                       o_lt,
    output logic                       o_eq
);
    logic [tomq_pkg::KEY_W-1:0] r_key;
    logic [PAYLOAD_BITS-1:0]    r_pay;
    logic                       r_valid;
    logic                       r_lt;
    logic                       r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_lt <= r_valid && (r_key < i_cmp_key);
                r_eq <= r_valid && (r_key == i_cmp_key);
            end
            priority if (i_ctl.op_pop) begin
                r_valid <= i_next_valid;
            end else if (i_ctl.op_insert && !r_lt) begin
                r_valid <= i_prev_lt ? 1'b1 : i_prev_valid;
            end else begin
                r_valid <= r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.op_pop) begin
            r_key <= i_next_key;
            r_pay <= i_next_pay;
        end else if (i_ctl.op_replace && r_eq) begin
            r_pay <= i_new_pay;
        end else if (i_ctl.op_insert && !r_lt) begin
            r_key <= i_prev_lt ? i_new_key : i_prev_key;
            r_pay <= i_prev_lt ? i_new_pay : i_prev_pay;
        end else begin
            r_key <= r_key;
            r_pay <= r_pay;
        end
    end

    assign o_key   = r_key;
    assign o_pay   = r_pay;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
endmodule

// ===== rtl/core/timestamp_ordered_message_queue_top.sv =====
// Timestamp ordered message queue: a chain of DEPTH cells kept sorted by key.
// A transferred request is registered with every cell's compare flags; the chain then updates and
// the result register loads once that register is empty or being read. Every cell compares
// in the transfer cycle. One request is in flight at a time; the next is taken while the previous result still waits.
// Reset (synchronous, active low) empties the queue: count and cell valid bits clear.
// Depends on tomq_pkg, tomq_in_if, tomq_out_if and tomq_cell.
module timestamp_ordered_message_queue_top #(
    parameter int DEPTH        = tomq_pkg::DEPTH,
    parameter int PAYLOAD_BITS = tomq_pkg::PAYLOAD_BITS,
    parameter int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tomq_in_if.sink  i_in,
    tomq_out_if.source o_out
);
    logic                       r_pend;
    tomq_pkg::t_kind            r_kind;
    logic [tomq_pkg::KEY_W-1:0] r_key;
    logic [PAYLOAD_BITS-1:0]    r_pay;
    logic [CNT_W-1:0]           r_count;

    logic                       r_ovalid;
    logic [CNT_W-1:0]           r_pos;
    logic                       r_repl;
    logic                       r_drop;
    logic                       r_found;
    logic [tomq_pkg::KEY_W-1:0] r_okey;
    logic [PAYLOAD_BITS-1:0]    r_opay;

    logic                       w_accept;
    logic                       w_apply;
    tomq_pkg::t_cell_ctl        w_ctl;

    logic [tomq_pkg::KEY_W-1:0] w_key   [DEPTH];
    logic [PAYLOAD_BITS-1:0]    w_pay   [DEPTH];
    logic [DEPTH-1:0]           w_valid;
    logic [DEPTH-1:0]           w_lt;
    logic [DEPTH-1:0]           w_eq;

    logic                       w_any_eq;
    logic                       w_full;
    logic [CNT_W-1:0]           w_lt_cnt;

    logic [CNT_W-1:0]           n_count;
    logic [CNT_W-1:0]           n_pos;
    logic                       n_repl;
    logic                       n_drop;
    logic                       n_found;
    logic [tomq_pkg::KEY_W-1:0] n_okey;
    logic [PAYLOAD_BITS-1:0]    n_opay;

    assign i_in.ready = !r_pend;
    assign w_accept   = i_in.valid && !r_pend;
    assign w_apply    = r_pend && (!r_ovalid || o_out.ready);

    assign w_any_eq = |w_eq;
    assign w_full   = (r_count == CNT_W'(DEPTH));

    // lt flags form a run from slot 0; encode the end of the run
    always_comb begin
        w_lt_cnt = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_lt[k] && ((k == DEPTH - 1) || !w_lt[(k + 1) % DEPTH])) begin
                w_lt_cnt = w_lt_cnt | CNT_W'(k + 1);
            end
        end
    end

    always_comb begin
        w_ctl.capture    = w_accept;
        w_ctl.op_pop     = 1'b0;
        w_ctl.op_replace = 1'b0;
        w_ctl.op_insert  = 1'b0;
        n_count = r_count;
        n_pos   = '0;
        n_repl  = 1'b0;
        n_drop  = 1'b0;
        n_found = 1'b0;
        n_okey  = '0;
        n_opay  = '0;
        unique case (r_kind)
            tomq_pkg::KIND_INSERT: begin
                priority if (w_any_eq) begin
                    w_ctl.op_replace = w_apply;
                    n_repl           = 1'b1;
                    n_pos            = r_count - w_lt_cnt - CNT_W'(1);
                end else if (w_full) begin
                    n_drop = 1'b1;
                end else begin
                    w_ctl.op_insert = w_apply;
                    n_pos           = r_count - w_lt_cnt;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            tomq_pkg::KIND_POP, tomq_pkg::KIND_PEEK: begin
                if (r_count != '0) begin
                    n_found = 1'b1;
                    n_okey  = w_key[0];
                    n_opay  = w_pay[0];
                    if (r_kind == tomq_pkg::KIND_POP) begin
                        w_ctl.op_pop = w_apply;
                        n_count      = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam int PREV = (k == 0) ? 0 : k - 1;
        localparam int NEXT = (k == DEPTH - 1) ? k : k + 1;

        tomq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_key    (i_in.key),
            .i_new_key    (r_key),
            .i_new_pay    (r_pay),
            .i_prev_key   (w_key[PREV]),
            .i_prev_pay   (w_pay[PREV]),
            .i_prev_valid ((k == 0) ? 1'b0 : w_valid[PREV]),
            .i_prev_lt    ((k == 0) ? 1'b1 : w_lt[PREV]),
            .i_next_key   (w_key[NEXT]),
            .i_next_pay   (w_pay[NEXT]),
            .i_next_valid ((k == DEPTH - 1) ? 1'b0 : w_valid[NEXT]),
            .o_key        (w_key[k]),
            .o_pay        (w_pay[k]),
            .o_valid      (w_valid[k]),
            .o_lt         (w_lt[k]),
            .o_eq         (w_eq[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_apply) begin
                r_pend <= 1'b0;
            end
            if (w_apply) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= tomq_pkg::t_kind'(i_in.kind);
            r_key  <= i_in.key;
            r_pay  <= i_in.payload;
        end
        if (w_apply) begin
            r_pos   <= n_pos;
            r_repl  <= n_repl;
            r_drop  <= n_drop;
            r_found <= n_found;
            r_okey  <= n_okey;
            r_opay  <= n_opay;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.position    = r_pos;
    assign o_out.replaced    = r_repl;
    assign o_out.dropped     = r_drop;
    assign o_out.found       = r_found;
    assign o_out.out_key     = r_okey;
    assign o_out.out_payload = r_opay;
    assign o_out.entry_count = r_count;
endmodule

// ===== rtl/core/tomq_checker.sv =====
// Port checker for the timestamp ordered message queue, bound to the top level.
// Depends on tomq_pkg and timestamp_ordered_message_queue_top.
module tomq_checker #(
    parameter int DEPTH = tomq_pkg::DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] i_position,
    input logic             i_replaced,
    input logic             i_dropped,
    input logic             i_found,
    input logic [CNT_W-1:0] i_entry_count
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in flight");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped |->
            !i_replaced && !i_found && (i_position == '0) && (i_entry_count == CNT_W'(DEPTH)))
        else $error("dropped insert with inconsistent result");

    a_found_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> !i_replaced && !i_dropped && (i_position == '0))
        else $error("pop or peek result carries insert fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_entry_count <= CNT_W'(DEPTH)) && (i_position < CNT_W'(DEPTH)))
        else $error("count or position out of range");
endmodule

bind timestamp_ordered_message_queue_top tomq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_tomq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_position    (o_out.position),
    .i_replaced    (o_out.replaced),
    .i_dropped     (o_out.dropped),
    .i_found       (o_out.found),
    .i_entry_count (o_out.entry_count)
);

// ===== tb/tomq_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the timestamp ordered message queue: watches both channels,
// keeps its own sorted copy of the queue and compares every result transfer.
// Depends on tomq_pkg, tomq_in_if and tomq_out_if.
module tomq_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tomq_in_if   i_req,
    tomq_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_replaced,
    output int   o_dropped,
    output int   o_empty_hits,
    output int   o_peak_fill
);
    import tomq_pkg::*;

    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [CNT_W-1:0]        position;
        logic                    replaced;
        logic                    dropped;
        logic                    found;
        logic [KEY_W-1:0]        out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [CNT_W-1:0]        entry_count;
    } t_queue_result;

    logic [KEY_W-1:0]        held_keys     [DEPTH];
    logic [PAYLOAD_BITS-1:0] held_payloads [DEPTH];
    int                      fill_count;
    t_queue_result           pending_results[$];

    int fail_total;
    int checked_total;
    int replaced_total;
    int dropped_total;
    int empty_total;
    int peak_fill;

    // Apply one operation to the shadow queue and return the result it must produce.
    function automatic t_queue_result apply_queue_op(input t_kind kind,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [PAYLOAD_BITS-1:0] handle);
        t_queue_result r;
        int            n;
        int            slot;
        r    = '0;
        n    = fill_count;
        slot = n;
        if (kind == KIND_INSERT) begin
            for (int i = 0; i < n; i++) begin
                if (slot == n && held_keys[i] <= key) begin
                    slot = i;
                end
            end
            if (slot < n && held_keys[slot] == key) begin
                held_payloads[slot] = handle;
                r.replaced          = 1'b1;
                r.position          = CNT_W'(slot);
            end else if (n >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                for (int j = n; j > slot; j--) begin
                    held_keys[j]     = held_keys[j-1];
                    held_payloads[j] = held_payloads[j-1];
                end
                held_keys[slot]     = key;
                held_payloads[slot] = handle;
                n++;
                r.position = CNT_W'(slot);
            end
        end else if (kind == KIND_POP || kind == KIND_PEEK) begin
            if (n > 0) begin
                r.found       = 1'b1;
                r.out_key     = held_keys[n-1];
                r.out_payload = held_payloads[n-1];
                if (kind == KIND_POP) begin
                    n--;
                end
            end
        end
        fill_count    = n;
        r.entry_count = CNT_W'(n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result seen;
        t_queue_result want;
        string         diff;
        if (!i_rst_n) begin
            fill_count = 0;
            pending_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.position    = i_res.position;
                seen.replaced    = i_res.replaced;
                seen.dropped     = i_res.dropped;
                seen.found       = i_res.found;
                seen.out_key     = i_res.out_key;
                seen.out_payload = i_res.out_payload;
                seen.entry_count = i_res.entry_count;
                if (pending_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORT) begin
                        $display("ERROR %0t: unexpected result pos=%0d rep=%0b drp=%0b fnd=%0b key=%h pay=%h cnt=%0d",
                                 $time, seen.position, seen.replaced, seen.dropped, seen.found,
                                 seen.out_key, seen.out_payload, seen.entry_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    diff = "";
                    if (seen.position !== want.position)       diff = {diff, " position"};
                    if (seen.replaced !== want.replaced)       diff = {diff, " replaced"};
                    if (seen.dropped !== want.dropped)         diff = {diff, " dropped"};
                    if (seen.found !== want.found)             diff = {diff, " found"};
                    if (seen.out_key !== want.out_key)         diff = {diff, " out_key"};
                    if (seen.out_payload !== want.out_payload) diff = {diff, " out_payload"};
                    if (seen.entry_count !== want.entry_count) diff = {diff, " entry_count"};
                    if (diff != "") begin
                        fail_total++;
                        if (fail_total <= MAX_REPORT) begin
                            $display("ERROR %0t: result %0d differs in%s", $time, checked_total, diff);
                            $display("  expected pos=%0d rep=%0b drp=%0b fnd=%0b key=%h pay=%h cnt=%0d",
                                     want.position, want.replaced, want.dropped, want.found,
                                     want.out_key, want.out_payload, want.entry_count);
                            $display("  actual   pos=%0d rep=%0b drp=%0b fnd=%0b key=%h pay=%h cnt=%0d",
                                     seen.position, seen.replaced, seen.dropped, seen.found,
                                     seen.out_key, seen.out_payload, seen.entry_count);
                        end
                    end
                    checked_total++;
                    if (want.replaced) replaced_total++;
                    if (want.dropped) dropped_total++;
                    if (!want.found && want.entry_count == 0 && !want.replaced) empty_total++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(apply_queue_op(t_kind'(i_req.kind), i_req.key,
                                                         i_req.payload));
                if (fill_count > peak_fill) peak_fill = fill_count;
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
        o_checked    <= checked_total;
        o_replaced   <= replaced_total;
        o_dropped    <= dropped_total;
        o_empty_hits <= empty_total;
        o_peak_fill  <= peak_fill;
    end

    initial begin
        fill_count     = 0;
        fail_total     = 0;
        checked_total  = 0;
        replaced_total = 0;
        dropped_total  = 0;
        empty_total    = 0;
        peak_fill      = 0;
    end

endmodule

// ===== tb/tb_timestamp_ordered_message_queue_top.sv =====
`timescale 1ns / 100ps
// Top of the timestamp ordered message queue testbench: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on tomq_pkg, tomq_in_if,
// tomq_out_if, tomq_result_checker and timestamp_ordered_message_queue_top.
module tb_timestamp_ordered_message_queue_top;
    import tomq_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_PCT     = 18;

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    int fail_count;
    int pending;
    int checked;
    int replaced_seen;
    int dropped_seen;
    int empty_seen;
    int peak_fill;
    int sent_total;
    int sent_by_kind [4];

    tomq_in_if  req_ch ();
    tomq_out_if res_ch ();

    timestamp_ordered_message_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    tomq_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_replaced   (replaced_seen),
        .o_dropped    (dropped_seen),
        .o_empty_hits (empty_seen),
        .o_peak_fill  (peak_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** timestamp_ordered_message_queue_top: FAILED **");
        $finish;
    end

    // Stall the result channel at random except during steady stretches.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] edge_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1;
            3:       return {KEY_W{1'b1}} - 64'd1;
            4:       return {1'b1, {(KEY_W-1){1'b0}}};
            default: return rand_key();
        endcase
    endfunction

    task automatic send_op(input t_kind kind, input logic [KEY_W-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] handle);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.key     <= key;
        req_ch.payload <= handle;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_by_kind[kind]++;
        sent_total++;
    endtask

    // Hold the request channel until every outstanding result has been seen.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [KEY_W-1:0] base;
        int               span;
        int               pick;
        int               round;
        t_kind            kind;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_NOP;
        req_ch.key     <= '0;
        req_ch.payload <= '0;
        steady      = 1'b0;
        sent_total  = 0;
        sent_by_kind = '{default: 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, key and handle extremes, replace, no-op, drain to empty.
        send_op(KIND_PEEK, '1, '1);
        send_op(KIND_POP, '1, '1);
        send_op(KIND_INSERT, '0, '0);
        send_op(KIND_INSERT, '0, '1);
        send_op(KIND_INSERT, '1, 32'h5a5a_5a5a);
        send_op(KIND_INSERT, 64'd1, 32'ha5a5_a5a5);
        send_op(KIND_INSERT, {KEY_W{1'b1}} - 64'd1, 32'h0000_0001);
        send_op(KIND_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 32'h8000_0000);
        send_op(KIND_INSERT, '1, 32'hffff_fffe);
        send_op(KIND_PEEK, '0, '0);
        send_op(KIND_NOP, rand_key(), $urandom());
        send_op(KIND_POP, '0, '0);
        send_op(KIND_POP, '0, '0);
        send_op(KIND_PEEK, '0, '0);
        send_op(KIND_INSERT, 64'h0123_4567_89ab_cdef, 32'h1357_9bdf);
        repeat (4) send_op(KIND_POP, rand_key(), $urandom());
        send_op(KIND_POP, '0, '0);
        send_op(KIND_NOP, '1, '1);
        drain_results();

        // Random: fill-to-full then drain sequences in about half the rounds, plus mixed and extreme traffic.
        round = 0;
        while (sent_total < RANDOM_ITEMS) begin
            steady = (round == 2);
            if (round == 4) drain_results();
            case ($urandom_range(0, 3))
                0, 1: begin
                    base = rand_key();
                    span = $urandom_range(70, 200);
                    repeat ($urandom_range(70, 140)) begin
                        if ($urandom_range(99) < 8) send_op(KIND_PEEK, rand_key(), $urandom());
                        else send_op(KIND_INSERT, base + $urandom_range(0, span), $urandom());
                    end
                    repeat ($urandom_range(30, 75)) begin
                        kind = ($urandom_range(99) < 85) ? KIND_POP : KIND_PEEK;
                        send_op(kind, rand_key(), $urandom());
                    end
                end
                2: begin
                    repeat (60) begin
                        pick = $urandom_range(99);
                        kind = (pick < 45) ? KIND_INSERT : (pick < 75) ? KIND_POP :
                               (pick < 93) ? KIND_PEEK : KIND_NOP;
                        if ($urandom_range(1)) send_op(kind, rand_key(), $urandom());
                        else send_op(kind, KEY_W'($urandom_range(0, 40)), $urandom());
                    end
                end
                default: begin
                    repeat (30) begin
                        pick = $urandom_range(99);
                        kind = (pick < 60) ? KIND_INSERT : (pick < 90) ? KIND_POP : KIND_PEEK;
                        send_op(kind, edge_key(), $urandom());
                    end
                end
            endcase
            round++;
        end
        steady = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests: %0d inserts, %0d pops, %0d peeks, %0d no-ops; %0d results checked.",
                 sent_total, sent_by_kind[KIND_INSERT], sent_by_kind[KIND_POP],
                 sent_by_kind[KIND_PEEK], sent_by_kind[KIND_NOP], checked);
        $display("Replaced %0d, dropped on full %0d, empty-queue results %0d, peak fill %0d of %0d.",
                 replaced_seen, dropped_seen, empty_seen, peak_fill, DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("** timestamp_ordered_message_queue_top: PASSED **");
        end else begin
            $display("** timestamp_ordered_message_queue_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tomq_pkg.sv
rtl/core/tomq_in_if.sv
rtl/core/tomq_out_if.sv
rtl/core/tomq_cell.sv
rtl/core/timestamp_ordered_message_queue_top.sv
rtl/core/tomq_checker.sv
tb/tomq_result_checker.sv
tb/tb_timestamp_ordered_message_queue_top.sv
